FILE: rtl/cmaef_pkg.sv
// Shared constants, types and helper functions of the circular mean angle filter.
`default_nettype none

package cmaef_pkg;

   localparam int HistDepth = 8;
   localparam int HistIdxW  = $clog2(HistDepth);
   localparam int FillW     = $clog2(HistDepth + 1);
   localparam int CordicSteps = 16;
   localparam int StepCntW  = $clog2(CordicSteps);
   localparam int XyW       = 24;
   localparam int ZW        = 25;
   localparam int AtanW     = 21;
   localparam int DivBits   = 33;
   localparam int DivCntW   = $clog2(DivBits + 1);

   localparam logic signed [ZW-1:0] FineQuarter = 25'sd2949120;
   localparam logic signed [ZW-1:0] FineHalf    = 25'sd5898240;
   localparam logic signed [XyW-1:0] StartMag   = 24'sd65536;
   localparam logic [15:0] GainCeil = 16'd64880;

   localparam logic [2:0] CSR_GAIN_MIN   = 3'd0;
   localparam logic [2:0] CSR_GAIN_MAX   = 3'd1;
   localparam logic [2:0] CSR_ERROR_GOOD = 3'd2;
   localparam logic [2:0] CSR_ERROR_BAD  = 3'd3;
   localparam logic [2:0] CSR_STEP_LIMIT = 3'd4;
   localparam logic [2:0] CSR_WINDOW_LEN = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_ROT, ST_VEC_START, ST_VEC, ST_MEAN, ST_GAIN,
      ST_MUL1, ST_MUL2, ST_DIV, ST_STEP_MUL, ST_STEP, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic vec;
   } cordic_ctl_type;

   function automatic logic [AtanW-1:0] atan_fine(input logic [StepCntW-1:0] i);
      logic [AtanW-1:0] a;
      case (i)
         4'd0:  a = 21'd1474560;
         4'd1:  a = 21'd870484;
         4'd2:  a = 21'd459940;
         4'd3:  a = 21'd233473;
         4'd4:  a = 21'd117189;
         4'd5:  a = 21'd58652;
         4'd6:  a = 21'd29333;
         4'd7:  a = 21'd14667;
         4'd8:  a = 21'd7334;
         4'd9:  a = 21'd3667;
         4'd10: a = 21'd1833;
         4'd11: a = 21'd917;
         4'd12: a = 21'd458;
         4'd13: a = 21'd229;
         4'd14: a = 21'd115;
         4'd15: a = 21'd57;
         default: a = '0;
      endcase
      return a;
   endfunction

   function automatic logic signed [15:0] wrap_angle(input logic signed [17:0] v);
      logic signed [17:0] r;
      r = v;
      if (v >= 18'sd23040) begin
         r = v - 18'sd46080;
      end else if (v < -18'sd23040) begin
         r = v + 18'sd46080;
      end
      return r[15:0];
   endfunction

   function automatic logic [15:0] cap_gain(input logic [15:0] g);
      return (g > GainCeil) ? GainCeil : g;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/cmaef_cordic.sv
// Iterative CORDIC unit, one micro-rotation per cycle, rotation or vectoring mode.
`default_nettype none

module cmaef_cordic import cmaef_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cordic_ctl_type        ctl,
   input  wire logic signed [XyW-1:0] x_start,
   input  wire logic signed [XyW-1:0] y_start,
   input  wire logic signed [ZW-1:0]  z_start,
   output logic signed [XyW-1:0]      x_res,
   output logic signed [XyW-1:0]      y_res,
   output logic signed [ZW-1:0]       z_res,
   output logic                       done
);

   logic signed [XyW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]  z_ff, z_in;
   logic [StepCntW-1:0]   step_ff, step_in;
   logic                  busy_ff, busy_in, vec_ff, vec_in, done_ff, done_in;
   logic                  sigma;
   logic signed [XyW-1:0] xs, ys;
   logic signed [ZW-1:0]  at;

   always_comb begin
      sigma = vec_ff ? (y_ff <= 0) : (z_ff >= 0);
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      at = $signed({{(ZW-AtanW){1'b0}}, atan_fine(step_ff)});
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      vec_in = vec_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         x_in = x_start;
         y_in = y_start;
         z_in = z_start;
         step_in = '0;
         busy_in = 1'b1;
         vec_in = ctl.vec;
      end else if (busy_ff) begin
         if (sigma) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == StepCntW'(CordicSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         vec_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         vec_ff  <= vec_in;
         step_ff <= step_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign x_res = x_ff;
   assign y_res = y_ff;
   assign z_res = z_ff;
   assign done  = done_ff;

endmodule

`default_nettype wire

FILE: rtl/circular_mean_adaptive_ema_angle_filter_top.sv
// Top level of the circular mean, adaptive gain, slew limited yaw filter.
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    req_raw_yaw, req_reproj_error
//  rsp      out        rsp_valid/rsp_ready    rsp_filtered_yaw, rsp_window_mean
//  csr      in         csr_write_enable       csr_index, csr_write_data
//
// Each angle in the window takes a load and a CORDIC rotation; then come the vectoring
// pass (skipped if the sums cancel), the mean and, once the filter is seeded, gain,
// divide (only for errors between the good and bad limits) and step. The time from the
// accepting edge to rsp_valid is set by the single shared CORDIC unit and the divide.
// Reset is synchronous; it clears control, fill count and filter state and loads the CSR defaults.
// req_ready is high only when idle; a result holds on rsp until taken.
`default_nettype none

module circular_mean_adaptive_ema_angle_filter_top import cmaef_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_raw_yaw,
   input  wire logic [15:0]        req_reproj_error,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_filtered_yaw,
   output logic signed [15:0]      rsp_window_mean,
   input  wire logic               csr_write_enable,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_write_data
);

   state_type state_ff, state_in;

   logic [15:0] gain_min_ff, gain_max_ff, error_good_ff, error_bad_ff;
   logic [14:0] step_limit_ff;
   logic [3:0]  window_len_ff;

   logic [15:0]          hist_ff [HistDepth];
   logic [HistIdxW-1:0]  wpos_ff, wpos_in, pos_ff, pos_in;
   logic [FillW-1:0]     fill_ff, fill_in, cnt_ff, cnt_in;
   logic signed [15:0]   smooth_ff, smooth_in, mean_ff, mean_in, diff_ff, diff_in;
   logic                 seeded_ff, seeded_in, zero_ff, zero_in;
   logic [15:0]          err_ff, err_in, gain_ff, gain_in, span_ff, span_in, quo_ff, quo_in;
   logic [15:0]          rem_ff, rem_in;
   logic signed [XyW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [31:0]          prod_ff, prod_in;
   logic [DivBits-1:0]   num_ff, num_in;
   logic [DivCntW-1:0]   dcnt_ff, dcnt_in;

   logic [15:0] mul_a, mul_b;
   logic [31:0] mul_p;
   logic        accept;

   cordic_ctl_type        cctl;
   logic signed [XyW-1:0] cx0, cy0, cx, cy;
   logic signed [ZW-1:0]  cz0, cz;
   logic                  cdone;

   logic [FillW-1:0]    wl_c, fill_new;
   logic [HistIdxW-1:0] rd_idx;
   logic signed [15:0]  ang;
   logic signed [ZW-1:0] zang, zr;
   logic [16:0]         trial;
   logic [15:0]         mag;
   logic [DivBits-1:0]  rsum;
   logic [16:0]         mstep;
   logic [14:0]         mclamp;

   cmaef_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .ctl     (cctl),
      .x_start (cx0),
      .y_start (cy0),
      .z_start (cz0),
      .x_res   (cx),
      .y_res   (cy),
      .z_res   (cz),
      .done    (cdone)
   );

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_filtered_yaw = smooth_ff;
   assign rsp_window_mean = mean_ff;
   assign mul_p = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (accept) state_in = ST_LOAD;
         ST_LOAD:      state_in = ST_ROT;
         ST_ROT:       if (cdone) state_in = (cnt_ff == FillW'(1)) ? ST_VEC_START : ST_LOAD;
         ST_VEC_START: state_in = (sx_ff == 0 && sy_ff == 0) ? ST_MEAN : ST_VEC;
         ST_VEC:       if (cdone) state_in = ST_MEAN;
         ST_MEAN:      state_in = seeded_ff ? ST_GAIN : ST_OUT;
         ST_GAIN: begin
            if (err_ff <= error_good_ff || err_ff >= error_bad_ff) begin
               state_in = ST_STEP_MUL;
            end else begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1:      state_in = ST_MUL2;
         ST_MUL2:      state_in = ST_DIV;
         ST_DIV:       if (dcnt_ff == DivCntW'(DivBits - 1)) state_in = ST_STEP_MUL;
         ST_STEP_MUL:  state_in = ST_STEP;
         ST_STEP:      state_in = ST_OUT;
         ST_OUT:       if (rsp_ready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      wpos_in = wpos_ff;
      pos_in = pos_ff;
      fill_in = fill_ff;
      cnt_in = cnt_ff;
      smooth_in = smooth_ff;
      mean_in = mean_ff;
      diff_in = diff_ff;
      seeded_in = seeded_ff;
      zero_in = zero_ff;
      err_in = err_ff;
      gain_in = gain_ff;
      span_in = span_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      prod_in = prod_ff;
      num_in = num_ff;
      dcnt_in = dcnt_ff;
      mul_a = '0;
      mul_b = '0;
      cctl = '0;
      cx0 = StartMag;
      cy0 = '0;
      cz0 = '0;

      wl_c = (window_len_ff == 4'd0) ? FillW'(1) :
             (window_len_ff > 4'(HistDepth)) ? FillW'(HistDepth) : FillW'(window_len_ff);
      fill_new = (fill_ff == FillW'(HistDepth)) ? fill_ff : fill_ff + 1'b1;
      rd_idx = pos_ff - 1'b1;
      ang = wrap_angle({{2{hist_ff[rd_idx][15]}}, hist_ff[rd_idx]});
      zang = {ang[15], ang, 8'b0};
      zr = (cz + 25'sd128) >>> 8;
      trial = {rem_ff, num_ff[DivBits-1]};
      mag = diff_ff[15] ? 16'(-diff_ff) : 16'(diff_ff);
      rsum = {1'b0, prod_ff} + 33'd32768;
      mstep = rsum[32:16];
      mclamp = (mstep > {2'b0, step_limit_ff}) ? step_limit_ff : mstep[14:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wpos_in = wpos_ff + 1'b1;
               pos_in = wpos_ff + 1'b1;
               fill_in = fill_new;
               cnt_in = (wl_c < fill_new) ? wl_c : fill_new;
               err_in = req_reproj_error;
               sx_in = '0;
               sy_in = '0;
            end
         end
         ST_LOAD: begin
            pos_in = rd_idx;
            cctl.start = 1'b1;
            cctl.vec = 1'b0;
            if (zang > FineQuarter) begin
               cz0 = zang - FineHalf;
               cx0 = -StartMag;
            end else if (zang < -FineQuarter) begin
               cz0 = zang + FineHalf;
               cx0 = -StartMag;
            end else begin
               cz0 = zang;
            end
         end
         ST_ROT: begin
            if (cdone) begin
               sx_in = sx_ff + cx;
               sy_in = sy_ff + cy;
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_VEC_START: begin
            zero_in = (sx_ff == 0 && sy_ff == 0);
            cctl.start = !(sx_ff == 0 && sy_ff == 0);
            cctl.vec = 1'b1;
            if (sx_ff < 0) begin
               cx0 = -sx_ff;
               cy0 = -sy_ff;
               cz0 = (sy_ff >= 0) ? FineHalf : -FineHalf;
            end else begin
               cx0 = sx_ff;
               cy0 = sy_ff;
            end
         end
         ST_MEAN: begin
            mean_in = zero_ff ? 16'sd0 : wrap_angle(zr[17:0]);
            if (!seeded_ff) begin
               smooth_in = mean_in;
               seeded_in = 1'b1;
            end else begin
               diff_in = wrap_angle({{2{mean_in[15]}}, mean_in} -
                                    {{2{smooth_ff[15]}}, smooth_ff});
            end
         end
         ST_GAIN: begin
            span_in = error_bad_ff - error_good_ff;
            if (err_ff <= error_good_ff) begin
               gain_in = cap_gain(gain_max_ff);
            end else if (err_ff >= error_bad_ff) begin
               gain_in = cap_gain(gain_min_ff);
            end
         end
         ST_MUL1: begin
            mul_a = gain_max_ff;
            mul_b = error_bad_ff - err_ff;
            prod_in = mul_p;
         end
         ST_MUL2: begin
            mul_a = gain_min_ff;
            mul_b = err_ff - error_good_ff;
            num_in = {1'b0, prod_ff} + {1'b0, mul_p} + {18'b0, span_ff[15:1]};
            rem_in = '0;
            quo_in = '0;
            dcnt_in = '0;
         end
         ST_DIV: begin
            num_in = {num_ff[DivBits-2:0], 1'b0};
            dcnt_in = dcnt_ff + 1'b1;
            if (trial >= {1'b0, span_ff}) begin
               rem_in = 16'(trial - {1'b0, span_ff});
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = trial[15:0];
               quo_in = {quo_ff[14:0], 1'b0};
            end
            if (dcnt_ff == DivCntW'(DivBits - 1)) begin
               gain_in = cap_gain(quo_in);
            end
         end
         ST_STEP_MUL: begin
            mul_a = mag;
            mul_b = gain_ff;
            prod_in = mul_p;
         end
         ST_STEP: begin
            if (diff_ff[15]) begin
               smooth_in = wrap_angle({{2{smooth_ff[15]}}, smooth_ff} - {3'b0, mclamp});
            end else begin
               smooth_in = wrap_angle({{2{smooth_ff[15]}}, smooth_ff} + {3'b0, mclamp});
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wpos_ff <= '0;
         fill_ff <= '0;
         smooth_ff <= '0;
         seeded_ff <= 1'b0;
         gain_min_ff <= 16'd3277;
         gain_max_ff <= 16'd22938;
         error_good_ff <= 16'd256;
         error_bad_ff <= 16'd1024;
         step_limit_ff <= 15'd256;
         window_len_ff <= 4'd5;
      end else begin
         state_ff <= state_in;
         wpos_ff <= wpos_in;
         fill_ff <= fill_in;
         smooth_ff <= smooth_in;
         seeded_ff <= seeded_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_GAIN_MIN:   gain_min_ff <= csr_write_data;
               CSR_GAIN_MAX:   gain_max_ff <= csr_write_data;
               CSR_ERROR_GOOD: error_good_ff <= csr_write_data;
               CSR_ERROR_BAD:  error_bad_ff <= csr_write_data;
               CSR_STEP_LIMIT: step_limit_ff <= csr_write_data[14:0];
               CSR_WINDOW_LEN: window_len_ff <= csr_write_data[3:0];
               default: begin
               end
            endcase
         end
      end
      if (accept) begin
         hist_ff[wpos_ff] <= req_raw_yaw;
      end
      pos_ff <= pos_in;
      cnt_ff <= cnt_in;
      mean_ff <= mean_in;
      diff_ff <= diff_in;
      zero_ff <= zero_in;
      err_ff <= err_in;
      gain_ff <= gain_in;
      span_ff <= span_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      prod_ff <= prod_in;
      num_ff <= num_in;
      dcnt_ff <= dcnt_in;
   end

endmodule

`default_nettype wire

FILE: rtl/cmaef_checker.sv
// Port level checks of the angle filter top level, bound to it.
`default_nettype none

module cmaef_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_filtered_yaw,
   input wire logic [15:0] rsp_window_mean
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered_yaw)
         && $stable(rsp_window_mean))
      else $error("result dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("request finished in a single cycle");

   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(rsp_filtered_yaw) >= -16'sd23040
         && $signed(rsp_filtered_yaw) <= 16'sd23039
         && $signed(rsp_window_mean) >= -16'sd23040
         && $signed(rsp_window_mean) <= 16'sd23039)
      else $error("angle outside half-open turn");

endmodule

bind circular_mean_adaptive_ema_angle_filter_top cmaef_checker u_cmaef_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_filtered_yaw (rsp_filtered_yaw),
   .rsp_window_mean  (rsp_window_mean)
);

`default_nettype wire

FILE: tb/sv/cmaef_checker.sv
// Checker for the angle filter: watches requests and responses, predicts and compares.
`default_nettype none

module cmaef_tb_checker import cmaef_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic signed [15:0] req_raw_yaw,
   input  wire logic [15:0]        req_reproj_error,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic signed [15:0] rsp_filtered_yaw,
   input  wire logic signed [15:0] rsp_window_mean,
   input  wire logic               csr_write_enable,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_write_data,
   output int                      fail_count,
   output int                      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [15:0] filtered_yaw;
      logic signed [15:0] window_mean;
   } yaw_result_type;

   localparam longint AtanTab[16] = '{1474560, 870484, 459940, 233473, 117189, 58652,
      29333, 14667, 7334, 3667, 1833, 917, 458, 229, 115, 57};
   localparam int ExpDepth = 16;

   yaw_result_type exp_ring[ExpDepth];
   int exp_head, exp_tail, exp_count;
   logic [15:0] gain_lo, gain_hi, err_good, err_bad;
   logic [14:0] slew_limit;
   logic [3:0]  win_len;
   logic signed [15:0] ring[HistDepth];
   int fill, wpos;
   int signed yaw_state;
   bit primed;

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic int wrap_turn(longint v);
      longint r;
      r = (v + 23040) % 46080;
      if (r < 0) r += 46080;
      return int'(r - 23040);
   endfunction

   task automatic rotate_add(int ang, inout longint sx, inout longint sy);
      longint z, x, y, nx, ny;
      z = longint'(wrap_turn(ang)) * 256;
      x = 65536;
      y = 0;
      if (z > 2949120) begin
         z -= 5898240; x = -x;
      end else if (z < -2949120) begin
         z += 5898240; x = -x;
      end
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - floor_shr(y, i); ny = y + floor_shr(x, i); z -= AtanTab[i];
         end else begin
            nx = x + floor_shr(y, i); ny = y - floor_shr(x, i); z += AtanTab[i];
         end
         x = nx; y = ny;
      end
      sx += x;
      sy += y;
   endtask

   function automatic int mean_angle(longint x, longint y);
      longint z, nx, ny;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? 5898240 : -5898240;
         x = -x; y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         if (y > 0) begin
            nx = x + floor_shr(y, i); ny = y - floor_shr(x, i); z += AtanTab[i];
         end else begin
            nx = x - floor_shr(y, i); ny = y + floor_shr(x, i); z -= AtanTab[i];
         end
         x = nx; y = ny;
      end
      return wrap_turn(floor_shr(z + 128, 8));
   endfunction

   function automatic longint quality_gain(longint e);
      longint g, span;
      if (e <= err_good) g = gain_hi;
      else if (e >= err_bad) g = gain_lo;
      else begin
         span = err_bad - err_good;
         g = (longint'(gain_hi) * (err_bad - e) + longint'(gain_lo) * (e - err_good)
              + span / 2) / span;
      end
      return (g > 64880) ? 64880 : g;
   endfunction

   task automatic predict_yaw(logic signed [15:0] raw, logic [15:0] err);
      int n, pos, d, mean;
      longint sx, sy, mag;
      yaw_result_type r;
      sx = 0;
      sy = 0;
      ring[wpos] = raw;
      wpos = (wpos + 1) % HistDepth;
      if (fill < HistDepth) fill++;
      n = win_len;
      if (n < 1) n = 1;
      if (n > HistDepth) n = HistDepth;
      if (n > fill) n = fill;
      pos = wpos;
      for (int k = 0; k < n; k++) begin
         pos = (pos + HistDepth - 1) % HistDepth;
         rotate_add(ring[pos], sx, sy);
      end
      mean = mean_angle(sx, sy);
      if (!primed) begin
         yaw_state = mean;
         primed = 1;
      end else begin
         d = wrap_turn(longint'(mean) - yaw_state);
         mag = (d < 0) ? -d : d;
         mag = (mag * quality_gain(err) + 32768) >>> 16;
         if (mag > slew_limit) mag = slew_limit;
         yaw_state = wrap_turn(longint'(yaw_state) + ((d < 0) ? -mag : mag));
      end
      r.filtered_yaw = 16'(yaw_state);
      r.window_mean = 16'(mean);
      exp_ring[exp_tail] = r;
      exp_tail = (exp_tail + 1) % ExpDepth;
      exp_count++;
   endtask

   assign pending_count = exp_count;

   always @(posedge clock) begin
      yaw_result_type want;
      if (reset) begin
         gain_lo <= 16'd3277;
         gain_hi <= 16'd22938;
         err_good <= 16'd256;
         err_bad <= 16'd1024;
         slew_limit <= 15'd256;
         win_len <= 4'd5;
         fill = 0;
         wpos = 0;
         yaw_state = 0;
         primed = 0;
         exp_head = 0;
         exp_tail = 0;
         exp_count = 0;
         fail_count <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_GAIN_MIN:   gain_lo <= csr_write_data;
               CSR_GAIN_MAX:   gain_hi <= csr_write_data;
               CSR_ERROR_GOOD: err_good <= csr_write_data;
               CSR_ERROR_BAD:  err_bad <= csr_write_data;
               CSR_STEP_LIMIT: slew_limit <= csr_write_data[14:0];
               CSR_WINDOW_LEN: win_len <= csr_write_data[3:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_yaw(req_raw_yaw, req_reproj_error);
         if (rsp_valid && rsp_ready) begin
            if (exp_count == 0) begin
               if (fail_count < 10) $display("unexpected response %0d %0d",
                  rsp_filtered_yaw, rsp_window_mean);
               fail_count <= fail_count + 1;
            end else begin
               want = exp_ring[exp_head];
               exp_head = (exp_head + 1) % ExpDepth;
               exp_count--;
               if (want.filtered_yaw !== rsp_filtered_yaw
                   || want.window_mean !== rsp_window_mean) begin
                  if (fail_count < 10)
                     $display("mismatch: filtered exp %0d got %0d, mean exp %0d got %0d",
                        want.filtered_yaw, rsp_filtered_yaw, want.window_mean,
                        rsp_window_mean);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench top: drives requests and register writes for the angle filter, gives the verdict.
`default_nettype none

module tb import cmaef_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic signed [15:0] req_raw_yaw, rsp_filtered_yaw, rsp_window_mean;
   logic [15:0] req_reproj_error, csr_write_data;
   logic csr_write_enable;
   logic [2:0] csr_index;
   int fail_count, pending_count, hold_cycles;
   bit rsp_random, hold_request, hold_taken;

   circular_mean_adaptive_ema_angle_filter_top i_dut (.*);
   cmaef_tb_checker i_checker (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int gap_len();
      int p;
      p = $urandom_range(99);
      if (p < 40) return 0;
      if (p < 95) return $urandom_range(3, 1);
      return $urandom_range(120, 20);
   endfunction

   task automatic send_yaw(logic signed [15:0] yaw, logic [15:0] err);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_raw_yaw <= yaw;
      req_reproj_error <= err;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
   endtask

   task automatic set_all(logic [15:0] gmin, logic [15:0] gmax, logic [15:0] eg,
                          logic [15:0] eb, logic [15:0] sl, logic [15:0] wl);
      write_reg(CSR_GAIN_MIN, gmin);
      write_reg(CSR_GAIN_MAX, gmax);
      write_reg(CSR_ERROR_GOOD, eg);
      write_reg(CSR_ERROR_BAD, eb);
      write_reg(CSR_STEP_LIMIT, sl);
      write_reg(CSR_WINDOW_LEN, wl);
      csr_write_enable <= 0;
   endtask

   task automatic random_run(int count);
      logic signed [15:0] base;
      int p;
      base = 16'($signed($urandom_range(46080)) - 23040);
      repeat (count) begin
         p = $urandom_range(99);
         if (p < 70) base = 16'(base + $signed($urandom_range(1200)) - 600);
         else if (p < 90) base = 16'($signed($urandom_range(46080)) - 23040);
         else base = 16'($urandom);
         send_yaw(base, (p & 1) ? 16'($urandom) : 16'($urandom_range(1400)));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         hold_cycles <= 0;
         hold_taken <= 0;
      end else if (hold_request && !hold_taken) begin
         rsp_ready <= 0;
         hold_cycles <= 400;
         hold_taken <= 1;
      end else if (hold_cycles > 0) begin
         rsp_ready <= 0;
         hold_cycles <= hold_cycles - 1;
      end else if (rsp_random && $urandom_range(99) < 2) begin
         rsp_ready <= 0;
         hold_cycles <= int'($urandom_range(120, 20));
      end else begin
         rsp_ready <= !rsp_random || ($urandom_range(99) < 60);
      end
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_raw_yaw = 0;
      req_reproj_error = 0;
      csr_write_enable = 0;
      csr_index = CSR_GAIN_MIN;
      csr_write_data = 0;
      hold_request = 0;
      rsp_random = 1;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_yaw(16'sd23040, 16'd0);
      send_yaw(-16'sd23040, 16'd65535);
      send_yaw(16'sd32767, 16'd256);
      send_yaw(-16'sd32768, 16'd1024);
      send_yaw(16'sd0, 16'd600);
      send_yaw(16'sd11520, 16'd300);
      send_yaw(-16'sd11520, 16'd900);
      drain();
      set_all(16'hFFFF, 16'hFFFF, 16'd500, 16'd500, 16'h7FFF, 16'd0);
      send_yaw(16'sd23039, 16'd500);
      send_yaw(16'sd0, 16'd501);
      send_yaw(-16'sd23040, 16'd0);
      drain();
      set_all(16'd0, 16'd0, 16'd65535, 16'd0, 16'd0, 16'd15);
      for (int k = 0; k < 10; k++) send_yaw(16'(k[0] ? 16'sd0 : 16'sd23040), 16'(k * 9000));
      drain();
      set_all(16'd0, 16'd64880, 16'd0, 16'd65535, 16'd23040, 16'd2);
      send_yaw(16'sd5760, 16'd0);
      send_yaw(-16'sd17280, 16'd65535);
      send_yaw(16'sd100, 16'd32768);
      drain();
      set_all(16'd3277, 16'd22938, 16'd256, 16'd1024, 16'd256, 16'd8);
      hold_request = 1;
      random_run(20);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         set_all(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                 16'($urandom_range(800)), 16'($urandom_range(1500)),
                 16'($urandom_range(23040)), 16'($urandom_range(9)));
         rsp_random = ph[0];
         random_run(330);
         drain();
      end
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: circular_mean_adaptive_ema_angle_filter_top.f
rtl/cmaef_pkg.sv
rtl/cmaef_cordic.sv
rtl/circular_mean_adaptive_ema_angle_filter_top.sv
rtl/cmaef_checker.sv
tb/sv/cmaef_checker.sv
tb/sv/tb.sv
